[rtl/core/histogram_equalization_8bit_defines.svh]
// Assertion macros for the histogram equalization block.
// Expects clk and rst_n in scope where used.
`ifndef HISTOGRAM_EQUALIZATION_8BIT_DEFINES_SVH
`define HISTOGRAM_EQUALIZATION_8BIT_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define HEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent sequence from the next cycle.
`define HEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);

`endif

[rtl/core/heq_pkg.sv]
// Shared types and constants for the histogram equalization block.
// No dependencies.
`default_nettype none
package heq_pkg;

    localparam int NUM_BINS = 256;
    localparam int BIN_W    = 8;
    localparam int CNT_W    = 23;
    localparam int RUN_W    = 31;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_BUILD = 2'd2,
        MODE_MAP   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_P1_RD,
        S_P1_ACC,
        S_P1_END,
        S_P2_CHK,
        S_P2_RD,
        S_P2_ACC,
        S_P2_PREP,
        S_P2_DIV,
        S_P2_WR,
        S_MAP_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic latch;
        logic clr_hist;
        logic bin_rd;
        logic use_gray;
        logic bin_inc;
        logic init;
        logic idx_clr;
        logic idx_inc;
        logic p1_acc;
        logic den_load;
        logic p2_acc;
        logic p2_prep;
        logic div_step;
        logic map_wr;
        logic map_set;
        logic map_clr;
        logic map_rd;
        logic out_load;
        logic out_build;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic den_zero;
        logic div_skip;
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

[rtl/core/heq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module heq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/heq_ctrl.sv]
// Controller for histogram equalization: sequences count, build and map.
// Depends on heq_pkg.
`default_nettype none
module heq_ctrl
    import heq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    output logic            out_valid,
    input  wire logic       out_ready,
    output cmd_t            cmd,
    input  wire status_t    sts
);

    state_t state_reg, state_next;
    logic   build_reg, build_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (mode_t'(mode))
                        MODE_CLEAR: cmd.clr_hist = 1'b1;
                        MODE_COUNT: state_next = S_CNT_RD;
                        MODE_BUILD:
                        begin
                            cmd.init    = 1'b1;
                            cmd.idx_clr = 1'b1;
                            build_next  = 1'b1;
                            state_next  = S_P1_RD;
                        end
                        MODE_MAP:
                        begin
                            build_next = 1'b0;
                            state_next = S_MAP_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD:
            begin
                cmd.bin_rd   = 1'b1;
                cmd.use_gray = 1'b1;
                state_next   = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.bin_inc  = 1'b1;
                cmd.use_gray = 1'b1;
                state_next   = S_IDLE;
            end
            S_P1_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = S_P1_ACC;
            end
            S_P1_ACC:
            begin
                cmd.p1_acc  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = sts.idx_last ? S_P1_END : S_P1_RD;
            end
            S_P1_END:
            begin
                cmd.den_load = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = S_P2_CHK;
            end
            S_P2_CHK:
            begin
                if (sts.den_zero)
                begin
                    cmd.map_clr = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_P2_RD;
                end
            end
            S_P2_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = S_P2_ACC;
            end
            S_P2_ACC:
            begin
                cmd.p2_acc = 1'b1;
                state_next = S_P2_PREP;
            end
            S_P2_PREP:
            begin
                cmd.p2_prep = 1'b1;
                state_next  = S_P2_DIV;
            end
            S_P2_DIV:
            begin
                if (sts.div_skip)
                begin
                    state_next = S_P2_WR;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = S_P2_WR;
                    end
                end
            end
            S_P2_WR:
            begin
                cmd.map_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.map_set = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_P2_RD;
                end
            end
            S_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_build = build_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/core/heq_dp.sv]
// Datapath for histogram equalization: bins, level map, cdf and divider.
// Depends on heq_pkg and heq_ram.
`default_nettype none
module heq_dp
    import heq_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = 4194304
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic [7:0]       in_gray,
    input  wire logic [7:0]       in_alpha,
    input  wire cmd_t             cmd,
    output status_t               sts,
    output logic      [7:0]       out_gray,
    output logic      [7:0]       out_alpha,
    output logic                  map_active
);

    localparam logic [31:0] CNT_MAX = 32'h007F_FFFF;
    localparam logic [CNT_W-1:0] CAP =
        CNT_W'((MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX);

    logic [CNT_W-1:0]    total_reg;
    logic                map_valid_reg;
    logic [NUM_BINS-1:0] bin_vld_reg;
    logic                rd_vld_reg;
    logic [7:0]          gray_reg, alpha_reg;
    logic [BIN_W-1:0]    idx_reg;
    logic [RUN_W-1:0]    run_reg;
    logic [CNT_W-1:0]    cmin_reg;
    logic                found_reg;
    logic signed [23:0]  den_reg;
    logic [31:0]         rem_reg;
    logic [30:0]         dvs_reg;
    logic [7:0]          q_reg;
    logic [2:0]          cnt_reg;
    logic                skip_reg;
    logic [7:0]          og_reg, oa_reg;
    logic                oact_reg;

    logic [BIN_W-1:0] bin_addr;
    logic [CNT_W-1:0] bin_rdata, bin_data, bin_wdata;
    logic [7:0]       map_rdata;

    assign bin_addr  = cmd.use_gray ? gray_reg : idx_reg;
    assign bin_data  = rd_vld_reg ? bin_rdata : '0;
    assign bin_wdata = (bin_data < CAP) ? bin_data + 1'b1 : bin_data;

    heq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_bins (
        .clk   (clk),
        .we    (cmd.bin_inc),
        .waddr (bin_addr),
        .wdata (bin_wdata),
        .re    (cmd.bin_rd),
        .raddr (bin_addr),
        .rdata (bin_rdata)
    );

    heq_ram #(.WIDTH(8), .DEPTH(NUM_BINS)) u_map (
        .clk   (clk),
        .we    (cmd.map_wr),
        .waddr (idx_reg),
        .wdata (q_reg),
        .re    (cmd.map_rd),
        .raddr (gray_reg),
        .rdata (map_rdata)
    );

    // level computation operands
    logic signed [31:0] n_val;
    logic [31:0]        an;
    logic [23:0]        ad;
    logic               sgn_diff;
    logic [31:0]        num;
    logic [31:0]        rem_sub;

    always_comb
    begin
        n_val    = $signed({1'b0, run_reg}) - $signed({9'd0, cmin_reg});
        an       = n_val[31] ? 32'(-n_val) : 32'(n_val);
        ad       = den_reg[23] ? 24'(-den_reg) : 24'(den_reg);
        sgn_diff = n_val[31] != den_reg[23];
        // an*510 + ad; an < ad < 2^23 on this path
        num      = {an[22:0], 9'd0} - {8'd0, an[22:0], 1'b0} + {9'd0, ad[22:0]};
        rem_sub  = rem_reg - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            map_valid_reg <= 1'b0;
            bin_vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.map_set)
            begin
                map_valid_reg <= 1'b1;
            end
            else if (cmd.map_clr)
            begin
                map_valid_reg <= 1'b0;
            end
            if (cmd.clr_hist)
            begin
                bin_vld_reg <= '0;
            end
            else if (cmd.bin_inc)
            begin
                bin_vld_reg[gray_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bin_rd)
        begin
            rd_vld_reg <= bin_vld_reg[bin_addr];
        end
        if (cmd.latch)
        begin
            gray_reg  <= in_gray;
            alpha_reg <= in_alpha;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
            run_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.init)
        begin
            found_reg <= 1'b0;
            cmin_reg  <= '0;
        end
        else if (cmd.p1_acc && !found_reg && bin_data != '0)
        begin
            // first nonzero bin is the first nonzero cdf value
            found_reg <= 1'b1;
            cmin_reg  <= bin_data;
        end
        if (cmd.den_load)
        begin
            den_reg <= $signed({1'b0, total_reg}) - $signed({1'b0, cmin_reg});
        end
        if (cmd.p2_acc)
        begin
            run_reg <= run_reg + RUN_W'(bin_data);
        end
        if (cmd.p2_prep)
        begin
            cnt_reg <= '0;
            rem_reg <= num;
            dvs_reg <= {ad[22:0], 8'd0};
            if (n_val == 0 || sgn_diff)
            begin
                skip_reg <= 1'b1;
                q_reg    <= 8'd0;
            end
            else if (an >= {8'd0, ad})
            begin
                skip_reg <= 1'b1;
                q_reg    <= 8'hFF;
            end
            else
            begin
                skip_reg <= 1'b0;
                q_reg    <= 8'd0;
            end
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            dvs_reg <= dvs_reg >> 1;
            if (rem_reg >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sub;
                q_reg   <= {q_reg[6:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[6:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            oact_reg <= map_valid_reg;
            if (cmd.out_build)
            begin
                og_reg <= 8'd0;
                oa_reg <= 8'd0;
            end
            else
            begin
                og_reg <= map_valid_reg ? map_rdata : gray_reg;
                oa_reg <= alpha_reg;
            end
        end
    end

    assign sts.idx_last = idx_reg == BIN_W'(NUM_BINS - 1);
    assign sts.den_zero = den_reg == 0;
    assign sts.div_skip = skip_reg;
    assign sts.div_last = cnt_reg == 3'd7;

    assign out_gray   = og_reg;
    assign out_alpha  = oa_reg;
    assign map_active = oact_reg;

endmodule
`default_nettype wire

[rtl/core/histogram_equalization_8bit.sv]
// Histogram equalization top level. Count: bin RAM read-modify-write per pixel.
// Map: level-map RAM read per pixel. Build: a pass over the bin RAM for the first nonzero
// cdf value, then a pass that runs the bit-serial level divider for each bin (skipped when
// the map goes inactive).
// Input taken only in idle; a held result stalls the next result-producing beat.
// Reset clears bin valid bits, map_valid, the pixel total and the handshakes.
`include "histogram_equalization_8bit_defines.svh"
`default_nettype none
module histogram_equalization_8bit
    import heq_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = 4194304
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       mode,
    input  wire logic [7:0]       in_gray,
    input  wire logic [7:0]       in_alpha,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [7:0]       out_gray,
    output logic      [7:0]       out_alpha,
    output logic                  map_active
);

    cmd_t    cmd;
    status_t sts;

    heq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    heq_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_gray    (in_gray),
        .in_alpha   (in_alpha),
        .cmd        (cmd),
        .sts        (sts),
        .out_gray   (out_gray),
        .out_alpha  (out_alpha),
        .map_active (map_active)
    );

    `HEQ_ASSERT_NEXT(a_no_result_count, in_valid && in_ready && !out_valid && (mode == MODE_CLEAR || mode == MODE_COUNT), !out_valid, "clear or count beat produced a result")
    `HEQ_ASSERT_NEXT(a_map_latency, in_valid && in_ready && !out_valid && mode == MODE_MAP, ##2 out_valid, "map beat result late")
    `HEQ_ASSERT(a_busy_no_ready, !(in_ready && cmd.div_step), "input ready while dividing")

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for histogram_equalization_8bit: directed table then random image passes, results
// checked against an in-bench histogram/level-map predictor, or the table's values for known rows.
// Depends on heq_pkg and the histogram_equalization_8bit RTL.
`default_nettype none
module tb;
    import heq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_CAP   = 4194304;
    localparam int IDLE_LIMIT  = 200000;
    localparam int DRAIN_CYC   = 40;

    typedef struct {
        mode_t       op;
        logic [7:0]  gray;
        logic [7:0]  alpha;
        logic        known;
        logic [7:0]  exp_gray;
        logic [7:0]  exp_alpha;
        logic        exp_active;
    } stim_row_t;

    typedef struct {
        logic [7:0] gray;
        logic [7:0] alpha;
        logic       active;
    } pix_out_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       mode = 2'd0;
    logic [7:0]       in_gray = '0;
    logic [7:0]       in_alpha = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_gray;
    logic [7:0]       out_alpha;
    logic             map_active;

    histogram_equalization_8bit dut (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .mode, .in_gray,
        .in_alpha, .out_valid, .out_ready, .out_gray, .out_alpha, .map_active
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    int unsigned    hist[NUM_BINS];
    logic [7:0]     lut[NUM_BINS];
    logic           lut_on;
    int unsigned    total_reg;
    pix_out_t       pending_pix[$];

    int  errors;
    int  n_beats_in, n_beats_out, n_builds;
    int  idle_cycles;
    bit  long_hold;
    bit  stall_off;

    function automatic logic [7:0] level_for(longint n, longint d);
        longint q;
        if (n == 0 || d == 0) return 8'd0;
        if ((n < 0) != (d < 0)) return 8'd0;
        if (n < 0) n = -n;
        if (d < 0) d = -d;
        if (n >= d) return 8'd255;
        q = (n * 510 + d) / (d * 2);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic predict_beat(mode_t op, logic [7:0] g, logic [7:0] a);
        longint   cum[NUM_BINS];
        longint   run, cmin, den;
        bit       found;
        pix_out_t r;
        case (op)
            MODE_CLEAR: foreach (hist[i]) hist[i] = 0;
            MODE_COUNT: if (hist[g] < COUNT_CAP) hist[g]++;
            MODE_BUILD:
            begin
                run = 0; cmin = 0; found = 0;
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    run += hist[i];
                    cum[i] = run;
                    if (!found && run != 0)
                    begin
                        cmin = run;
                        found = 1;
                    end
                end
                den = longint'(total_reg) - cmin;
                if (den == 0)
                    lut_on = 1'b0;
                else
                begin
                    for (int i = 0; i < NUM_BINS; i++)
                        lut[i] = level_for(cum[i] - cmin, den);
                    lut_on = 1'b1;
                end
                r.gray = '0; r.alpha = '0; r.active = lut_on;
                pending_pix.push_back(r);
                n_builds++;
            end
            default:
            begin
                r.gray = lut_on ? lut[g] : g;
                r.alpha = a; r.active = lut_on;
                pending_pix.push_back(r);
            end
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            pix_out_t e;
            n_beats_out++;
            if (pending_pix.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_pix.pop_front();
                if (out_gray !== e.gray)
                begin
                    $error("out_gray exp %0d got %0d", e.gray, out_gray);
                    errors++;
                end
                if (out_alpha !== e.alpha)
                begin
                    $error("out_alpha exp %0d got %0d", e.alpha, out_alpha);
                    errors++;
                end
                if (map_active !== e.active)
                begin
                    $error("map_active exp %0d got %0d", e.active, map_active);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
        begin
            out_ready <= 1'b0;
            hold = 0;
            while (hold < 400)
            begin
                @(posedge clk);
                hold++;
            end
            long_hold = 0;
        end
        else if (stall_off)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (++idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    int burst_left = 0;

    // valid stays up across a burst; it drops only for a gap or a drain
    task automatic send_beat(mode_t op, logic [7:0] g, logic [7:0] a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode     <= op;
        in_gray  <= g;
        in_alpha <= a;
        do @(posedge clk); while (!in_ready);
        predict_beat(op, g, a);
        n_beats_in++;
    endtask

    // idle point: everything back, then room for the block to settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_total(int unsigned v);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        total_reg = v & 32'h7FFFFF;
    endtask

    stim_row_t dir_tab[$];

    function automatic stim_row_t row(mode_t op, int g, int a, bit k = 1'b0,
                                      int eg = 0, int ea = 0, bit act = 1'b0);
        stim_row_t s;
        s.op = op; s.gray = 8'(g); s.alpha = 8'(a); s.known = k;
        s.exp_gray = 8'(eg); s.exp_alpha = 8'(ea); s.exp_active = act;
        return s;
    endfunction

    task automatic random_image(int npix, int unsigned tot_sel, int nmap);
        int unsigned lo, hi;
        int tot;
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
        send_beat(MODE_CLEAR, 8'($urandom), 8'($urandom));
        for (int i = 0; i < npix; i++)
            send_beat(MODE_COUNT, 8'($urandom_range(lo, hi)), 8'($urandom));
        case (tot_sel)
            0: tot = npix;
            1: tot = npix + $urandom_range(1, 50);
            2: tot = $urandom_range(0, npix);
            default: tot = 23'h7FFFFF;
        endcase
        set_total(tot);
        send_beat(MODE_BUILD, 8'($urandom), 8'($urandom));
        for (int i = 0; i < nmap; i++)
            send_beat(MODE_MAP, 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        errors = 0;
        lut_on = 1'b0; total_reg = 0;
        foreach (hist[i]) hist[i] = 0;
        long_hold = 0; stall_off = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: map inactive, pixels pass through
        dir_tab.push_back(row(MODE_MAP, 8'h00, 8'hFF, 1'b1, 8'h00, 8'hFF, 1'b0));
        dir_tab.push_back(row(MODE_MAP, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h00, 1'b0));
        dir_tab.push_back(row(MODE_MAP, 8'hA5, 8'h5A, 1'b1, 8'hA5, 8'h5A, 1'b0));
        // empty histogram with total 0 is degenerate
        dir_tab.push_back(row(MODE_BUILD, 0, 0, 1'b1, 0, 0, 1'b0));
        dir_tab.push_back(row(MODE_COUNT, 8'h00, 0));
        dir_tab.push_back(row(MODE_COUNT, 8'hFF, 0));
        dir_tab.push_back(row(MODE_COUNT, 8'hFF, 0));
        dir_tab.push_back(row(MODE_COUNT, 8'h80, 0));
        // cdfmin 1, total 0: negative denominator
        dir_tab.push_back(row(MODE_BUILD, 0, 0));
        dir_tab.push_back(row(MODE_MAP, 8'h00, 8'h11));
        dir_tab.push_back(row(MODE_MAP, 8'hFF, 8'h22));
        dir_tab.push_back(row(MODE_MAP, 8'h80, 8'h33));
        // clear keeps the map
        dir_tab.push_back(row(MODE_CLEAR, 0, 0));
        dir_tab.push_back(row(MODE_MAP, 8'h80, 8'h44));
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].known) wait_drained();
            if (dir_tab[i].known) pending_pix.delete();
            send_beat(dir_tab[i].op, dir_tab[i].gray, dir_tab[i].alpha);
            if (dir_tab[i].known)
            begin
                pending_pix.pop_back();
                pending_pix.push_back('{dir_tab[i].exp_gray, dir_tab[i].exp_alpha,
                                        dir_tab[i].exp_active});
            end
        end

        // consistent total, then extreme total
        set_total(4);
        random_image(4, 0, 8);
        set_total(23'h7FFFFF);
        send_beat(MODE_BUILD, 8'd0, 8'd0);
        send_beat(MODE_MAP, 8'hFF, 8'hFF);

        // long receiver hold while maps keep coming
        wait_drained();
        long_hold = 1;
        for (int i = 0; i < 30; i++)
            send_beat(MODE_MAP, 8'($urandom), 8'($urandom));

        // random images
        while (n_beats_in < 460)
        begin
            stall_off = ($urandom_range(0, 4) == 0);
            random_image($urandom_range(1, 24), $urandom_range(0, 3),
                         $urandom_range(4, 30));
        end

        // sender pauses until everything is back
        wait_drained();
        stall_off = 1;
        for (int i = 0; i < 20; i++)
            send_beat(MODE_MAP, 8'($urandom), 8'($urandom));
        wait_drained();

        $display("Run covered %0d input beats, %0d result beats, %0d map builds",
                 n_beats_in, n_beats_out, n_builds);
        $display("with saturating-free counts, consistent/short/long/max totals.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[histogram_equalization_8bit.f]
+incdir+rtl/core
rtl/core/heq_pkg.sv
rtl/core/heq_ram.sv
rtl/core/heq_ctrl.sv
rtl/core/heq_dp.sv
rtl/core/histogram_equalization_8bit.sv
verif/tb.sv
